// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/stfs_pkg.sv =====
// Shared constants, request codes and types of the session token store.
package stfs_pkg;

  localparam int TableEntries = 8;
  localparam int KeyBytes     = 16;
  localparam int KeyW         = KeyBytes * 8;
  localparam int HalfW        = KeyW / 2;
  localparam int CntW         = $clog2(TableEntries + 1);
  localparam int OutCntW      = 4;
  localparam int ReqW         = 2;

  localparam logic [ReqW-1:0] ReqLookup = 2'd0;
  localparam logic [ReqW-1:0] ReqInsert = 2'd1;
  localparam logic [ReqW-1:0] ReqClear  = 2'd2;

  typedef struct packed {
    logic shift;   // take the neighbour's token this cycle
    logic cmp_en;  // register a fresh compare result this cycle
    logic live;    // the cell holds a stored entry
  } cell_ctrl_t;

endpackage

// ===== hdl/stfs_cell.sv =====
// One storage cell of the token chain: holds a token and compares it.
module stfs_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  stfs_pkg::cell_ctrl_t     ctrl_i,
  input  logic [stfs_pkg::HalfW-1:0] prev_hi_i,
  input  logic [stfs_pkg::HalfW-1:0] prev_lo_i,
  input  logic [stfs_pkg::HalfW-1:0] cmp_hi_i,
  input  logic [stfs_pkg::HalfW-1:0] cmp_lo_i,
  output logic [stfs_pkg::HalfW-1:0] tok_hi_o,
  output logic [stfs_pkg::HalfW-1:0] tok_lo_o,
  output logic                     match_o
);

  logic [stfs_pkg::HalfW-1:0] tok_hi_q, tok_lo_q;
  logic                       match_q, match_d;

  // Only a cell holding a stored entry may report a hit.
  assign match_d = ctrl_i.live && (tok_hi_q == cmp_hi_i) && (tok_lo_q == cmp_lo_i);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      tok_hi_q <= prev_hi_i;
      tok_lo_q <= prev_lo_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctrl_i.cmp_en) begin
      match_q <= match_d;
    end
  end

  assign tok_hi_o = tok_hi_q;
  assign tok_lo_o = tok_lo_q;
  assign match_o  = match_q;

endmodule

// ===== hdl/session_token_fifo_store_top.sv =====
// Top level of the session token store: a shifting chain of token cells.
//
//  channel | direction | signals
//  --------+-----------+---------------------------------------------------
//  request | in        | in_valid_i, in_ready_o, req_type_i, token_high_i,
//          |           | token_low_i
//  result  | out       | out_valid_o, out_ready_i, found_o, entry_count_o,
//          |           | evicted_o
//
// In each transaction the accept edge shifts the chain on an insert, or
// registers each cell's compare on a lookup; the load edge, taken once the
// output register is free or being drained, ORs the cell hits into the
// output register. The request side is ready again after that load.
// Reset empties the store at once; no clearing pass is needed, as token
// cells are only compared when the entry count covers them.
// A stalled result holds back the load of the next request until it is taken.
module session_token_fifo_store_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [stfs_pkg::ReqW-1:0]        req_type_i,
  input  logic [stfs_pkg::HalfW-1:0]       token_high_i,
  input  logic [stfs_pkg::HalfW-1:0]       token_low_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             found_o,
  output logic [stfs_pkg::OutCntW-1:0]     entry_count_o,
  output logic                             evicted_o
);

  localparam int N = stfs_pkg::TableEntries;

  // Control state: request in flight, result waiting, and the fill count.
  logic                      busy_q, busy_d;
  logic                      out_valid_q, out_valid_d;
  logic [stfs_pkg::CntW-1:0] count_q, count_d;

  // Details of the request in flight, captured at the accept edge.
  logic                      pend_lookup_q;
  logic                      pend_evict_q;
  logic [stfs_pkg::CntW-1:0] pend_count_q;

  // Output register.
  logic                         found_q;
  logic [stfs_pkg::OutCntW-1:0] entry_count_q;
  logic                         evicted_q;

  logic accept, load_out, is_insert, is_clear, is_lookup, full;
  logic evict_d;

  // Token chain: tap 0 is the incoming token, tap i+1 is cell i's content.
  logic [stfs_pkg::HalfW-1:0] chain_hi [N+1];
  logic [stfs_pkg::HalfW-1:0] chain_lo [N+1];
  logic [N-1:0]               cell_hit;
  stfs_pkg::cell_ctrl_t       cell_ctrl [N];

  assign accept    = in_valid_i && in_ready_o;
  assign load_out  = busy_q && (!out_valid_q || out_ready_i);
  assign is_lookup = (req_type_i == stfs_pkg::ReqLookup);
  assign is_insert = (req_type_i == stfs_pkg::ReqInsert);
  assign is_clear  = (req_type_i == stfs_pkg::ReqClear);
  assign full      = (count_q == stfs_pkg::CntW'(N));

  assign in_ready_o = !busy_q;

  // The newest entry enters cell 0 and each insert pushes every entry one
  // cell further along; the cell at the far end drops the oldest entry
  // when the store is full. Live cells are therefore cells 0 to count-1.
  assign chain_hi[0] = token_high_i;
  assign chain_lo[0] = token_low_i;

  for (genvar i = 0; i < N; i++) begin : g_cell
    assign cell_ctrl[i].shift  = accept && is_insert;
    assign cell_ctrl[i].cmp_en = accept && is_lookup;
    assign cell_ctrl[i].live   = (count_q > stfs_pkg::CntW'(i));

    stfs_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (cell_ctrl[i]),
      .prev_hi_i (chain_hi[i]),
      .prev_lo_i (chain_lo[i]),
      .cmp_hi_i  (token_high_i),
      .cmp_lo_i  (token_low_i),
      .tok_hi_o  (chain_hi[i+1]),
      .tok_lo_o  (chain_lo[i+1]),
      .match_o   (cell_hit[i])
    );
  end

  // Count update and eviction flag for the request at the input.
  always_comb begin
    count_d = count_q;
    evict_d = 1'b0;
    case (req_type_i)
      stfs_pkg::ReqInsert: begin
        if (full) begin
          evict_d = 1'b1;
        end else begin
          count_d = count_q + stfs_pkg::CntW'(1);
        end
      end
      stfs_pkg::ReqClear: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (load_out) begin
      busy_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_lookup_q <= is_lookup;
      pend_evict_q  <= evict_d && is_insert;
      pend_count_q  <= is_clear ? '0 : count_d;
    end
    if (load_out) begin
      found_q       <= pend_lookup_q && (|cell_hit);
      evicted_q     <= pend_evict_q;
      entry_count_q <= stfs_pkg::OutCntW'(pend_count_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign entry_count_o = entry_count_q;
  assign evicted_o     = evicted_q;

endmodule

// ===== hdl/stfs_checker.sv =====
// Port-level assertions for the session token store, bound to its top level.
`include "assert_macros.svh"

module stfs_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic                         found_o,
  input logic [stfs_pkg::OutCntW-1:0] entry_count_o,
  input logic                         evicted_o
);

  // A stalled result keeps its valid and its payload.
  `ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
              out_valid_o && $stable(found_o) && $stable(entry_count_o) && $stable(evicted_o))

  // One transaction at a time: the block is busy in the cycle after an accept.
  `ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

  // A hit and an eviction never come from the same request.
  `ASSERT_IMP(a_found_xor_evict, clk_i, rst_ni, out_valid_o && found_o, !evicted_o)

  // An eviction only happens with the store full.
  `ASSERT_IMP(a_evict_full, clk_i, rst_ni, out_valid_o && evicted_o,
              entry_count_o == stfs_pkg::OutCntW'(stfs_pkg::TableEntries))

endmodule

bind session_token_fifo_store_top stfs_checker u_stfs_checker (.*);
